/* sv/alu_asc_pkg.sv */
// Shared types and constants of the add/subtract/convert execution unit.
// No dependencies; every other file of the block refers to it by scoped names.
package alu_asc_pkg;

   typedef enum logic [2:0] {
      OP_ADD  = 3'd0,
      OP_ADDS = 3'd1,
      OP_SUB  = 3'd2,
      OP_SUBS = 3'd3,
      OP_ITOF = 3'd4,
      OP_FTOI = 3'd5
   } op_type;

   localparam int FLAG_W       = 12;
   localparam int FLAG_OVF_BIT = 11;
   localparam int FLAG_SGN_BIT = 7;
   localparam int FLAG_ZER_BIT = 6;
   localparam int FLAG_CRY_BIT = 0;

   localparam logic [7:0] EXP_BIAS    = 8'd127;
   localparam logic [7:0] EXP_MAX_INT = 8'd158;   // bias + 31
   localparam logic [4:0] MANT_BITS   = 5'd23;

   localparam logic [31:0] SAT_POS = 32'h7FFF_FFFF;
   localparam logic [31:0] SAT_NEG = 32'hFFFF_FFFF;

   typedef struct packed {
      logic [31:0]       value;
      logic [FLAG_W-1:0] flags;
      logic              error;
   } res_type;

endpackage

/* sv/alu_asc_addsub.sv */
// 32-bit adder with overflow, sign, zero and carry flags for ADD/ADDS/SUB/SUBS.
// Depends on alu_asc_pkg for the opcode type, flag positions and result struct.
module alu_asc_addsub (
   input  alu_asc_pkg::op_type  op,
   input  logic [31:0]          operand_a,
   input  logic [31:0]          operand_b,
   output alu_asc_pkg::res_type res
);

   logic        is_sub;
   logic [31:0] addend;
   logic [32:0] wide;
   logic        ovf;

   assign is_sub = (op == alu_asc_pkg::OP_SUB) || (op == alu_asc_pkg::OP_SUBS);
   // subtract adds the two's-complement negation, so minus zero carries nothing
   assign addend = is_sub ? (~operand_b + 32'd1) : operand_b;
   assign wide   = {1'b0, operand_a} + {1'b0, addend};
   assign ovf    = (operand_a[31] == addend[31]) && (wide[31] != operand_a[31]);

   always_comb begin
      res.value = wide[31:0];
      res.flags = '0;
      res.flags[alu_asc_pkg::FLAG_OVF_BIT] = ovf;
      res.flags[alu_asc_pkg::FLAG_SGN_BIT] = wide[31];
      res.flags[alu_asc_pkg::FLAG_ZER_BIT] = (wide[31:0] == 32'd0);
      res.flags[alu_asc_pkg::FLAG_CRY_BIT] = wide[32];
      res.error = (op == alu_asc_pkg::OP_ADD) ? wide[32] : ovf;
   end

endmodule

/* sv/alu_asc_itof.sv */
// Signed 32-bit integer to single precision, round to nearest even.
// Depends on alu_asc_pkg for the exponent bias.
module alu_asc_itof (
   input  logic [31:0] operand_a,
   output logic [31:0] result_value
);

   function automatic logic [4:0] msb_pos(input logic [31:0] v);
      logic [4:0] p;
      p = 5'd0;
      for (int i = 0; i < 32; i++) begin
         if (v[i]) begin
            p = 5'(i);
         end
      end
      return p;
   endfunction

   logic        sign;
   logic [31:0] mag;
   logic [4:0]  p;
   logic [31:0] norm;
   logic        round_up;
   logic [24:0] mant;
   logic [7:0]  exp_val;

   assign sign = operand_a[31];
   assign mag  = sign ? (~operand_a + 32'd1) : operand_a;
   assign p    = msb_pos(mag);
   // leading one moves to bit 31: mantissa in [31:8], guard at 7, sticky below
   assign norm     = mag << (5'd31 - p);
   assign round_up = norm[7] && ((|norm[6:0]) || norm[8]);
   assign mant     = {1'b0, norm[31:8]} + {24'd0, round_up};
   assign exp_val  = {3'd0, p} + alu_asc_pkg::EXP_BIAS + {7'd0, mant[24]};

   always_comb begin
      if (mag == 32'd0) begin
         result_value = 32'd0;
      end else if (mant[24]) begin
         // rounding carried out: mantissa field becomes zero
         result_value = {sign, exp_val, 23'd0};
      end else begin
         result_value = {sign, exp_val, mant[22:0]};
      end
   end

endmodule

/* sv/alu_asc_ftoi.sv */
// Single precision to 32-bit integer by truncation, saturating on a large exponent.
// Depends on alu_asc_pkg for exponent limits, saturation values and the result struct.
module alu_asc_ftoi (
   input  logic [31:0]          operand_a,
   output alu_asc_pkg::res_type res
);

   logic        sign;
   logic [7:0]  exp_f;
   logic [4:0]  e;
   logic [31:0] sig;
   logic [31:0] mag;
   logic        ovf;

   assign sign  = operand_a[31];
   assign exp_f = operand_a[30:23];
   assign ovf   = exp_f > alu_asc_pkg::EXP_MAX_INT;
   assign e     = 5'(exp_f - alu_asc_pkg::EXP_BIAS);
   assign sig   = {8'd0, 1'b1, operand_a[22:0]};

   always_comb begin
      if (exp_f < alu_asc_pkg::EXP_BIAS) begin
         mag = 32'd0;
      end else if (e <= alu_asc_pkg::MANT_BITS) begin
         mag = sig >> (alu_asc_pkg::MANT_BITS - e);
      end else begin
         mag = sig << (e - alu_asc_pkg::MANT_BITS);
      end
   end

   always_comb begin
      res.flags = '0;
      if (ovf) begin
         res.value = sign ? alu_asc_pkg::SAT_NEG : alu_asc_pkg::SAT_POS;
         res.flags[alu_asc_pkg::FLAG_OVF_BIT] = 1'b1;
         res.error = 1'b1;
      end else begin
         res.value = sign ? (~mag + 32'd1) : mag;
         res.error = 1'b0;
      end
   end

endmodule

/* sv/alu_add_sub_int_float_convert.sv */
// Top level of the 32-bit add/subtract and int/float conversion unit.
// Depends on alu_asc_pkg, alu_asc_addsub, alu_asc_itof and alu_asc_ftoi.
//
// Every request yields exactly one response; a new request is taken every cycle while
// the response side is not stalled. The request is
// captured in an input register, the adder, the leading-one search with normalizing
// shifter and rounding incrementer (ITOF), or the truncating shifter (FTOI) work
// between that register and the response register, and the result is registered at
// the output. The opcode travels in req_tuser, operand_a and operand_b in req_tdata.
// The response carries result_value and flag_word (bit 11 overflow, bit 7 sign,
// bit 6 zero, bit 0 carry) in rsp_tdata and the error bit in rsp_tuser. Opcodes 6
// and 7 return zero with error set. Both stages advance together whenever the output
// register is empty or its response is taken, so ready depends on rsp_tready.
module alu_add_sub_int_float_convert (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [63:0] req_tdata,   // [31:0] operand_a, [63:32] operand_b
   input  logic [2:0]  req_tuser,   // [2:0] opcode
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata,   // [31:0] result_value, [43:32] flag_word, rest zero
   output logic [0:0]  rsp_tuser    // [0] error
);

   // input register stage
   logic                s1_valid_ff, s1_valid_in;
   alu_asc_pkg::op_type s1_op_ff;
   logic [31:0]         s1_a_ff;
   logic [31:0]         s1_b_ff;

   // output register stage
   logic                 out_valid_ff, out_valid_in;
   alu_asc_pkg::res_type out_res_ff, out_res_in;

   logic                 advance;
   alu_asc_pkg::res_type addsub_res;
   alu_asc_pkg::res_type ftoi_res;
   logic [31:0]          itof_value;

   // advance both stages when the output slot is free or being emptied
   assign advance    = !out_valid_ff || rsp_tready;
   assign req_tready = advance;

   assign s1_valid_in  = advance ? req_tvalid : s1_valid_ff;
   assign out_valid_in = advance ? s1_valid_ff : out_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // payload: capture the request, hold while stalled
   always_ff @(posedge clock) begin
      if (advance) begin
         s1_op_ff   <= alu_asc_pkg::op_type'(req_tuser);
         s1_a_ff    <= req_tdata[31:0];
         s1_b_ff    <= req_tdata[63:32];
         out_res_ff <= out_res_in;
      end
   end

   alu_asc_addsub u_addsub (
      .op        (s1_op_ff),
      .operand_a (s1_a_ff),
      .operand_b (s1_b_ff),
      .res       (addsub_res)
   );

   alu_asc_itof u_itof (
      .operand_a    (s1_a_ff),
      .result_value (itof_value)
   );

   alu_asc_ftoi u_ftoi (
      .operand_a (s1_a_ff),
      .res       (ftoi_res)
   );

   // pick the unit that matches the opcode; undefined codes flag an error
   always_comb begin
      unique case (s1_op_ff)
         alu_asc_pkg::OP_ADD, alu_asc_pkg::OP_ADDS,
         alu_asc_pkg::OP_SUB, alu_asc_pkg::OP_SUBS: begin
            out_res_in = addsub_res;
         end
         alu_asc_pkg::OP_ITOF: begin
            out_res_in.value = itof_value;
            out_res_in.flags = '0;
            out_res_in.error = 1'b0;
         end
         alu_asc_pkg::OP_FTOI: begin
            out_res_in = ftoi_res;
         end
         default: begin
            out_res_in.value = 32'd0;
            out_res_in.flags = '0;
            out_res_in.error = 1'b1;
         end
      endcase
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {4'd0, out_res_ff.flags, out_res_ff.value};
   assign rsp_tuser  = out_res_ff.error;

`ifndef SYNTHESIS
   a_undef_op_error: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && advance && (s1_op_ff != alu_asc_pkg::OP_ADD) &&
       (s1_op_ff != alu_asc_pkg::OP_ADDS) && (s1_op_ff != alu_asc_pkg::OP_SUB) &&
       (s1_op_ff != alu_asc_pkg::OP_SUBS) && (s1_op_ff != alu_asc_pkg::OP_ITOF) &&
       (s1_op_ff != alu_asc_pkg::OP_FTOI))
      |=> (rsp_tuser[0] && (rsp_tdata == 48'd0)))
      else $error("undefined opcode did not return a zero error response");

   a_itof_no_error: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && advance && (s1_op_ff == alu_asc_pkg::OP_ITOF))
      |=> (!rsp_tuser[0] && (rsp_tdata[43:32] == 12'd0)))
      else $error("int to float response carries flags or error");

   a_accept_fills_stage: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> s1_valid_ff)
      else $error("accepted request lost before the input stage");

   a_rsp_from_stage: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(s1_valid_ff))
      else $error("response appeared without a request in the input stage");

   a_stage_held_on_stall: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && !advance) |=> (s1_valid_ff && $stable(s1_a_ff) && $stable(s1_b_ff)))
      else $error("input stage changed while the output was stalled");
`endif

endmodule

/* verif/tb_alu_add_sub_int_float_convert.sv */
// Self-checking testbench for the add/subtract and int/float conversion unit.
// Depends on alu_asc_pkg and alu_add_sub_int_float_convert; predicts every response
// internally and compares it field by field under random request and response stalls.
`timescale 1ns / 1ps

module tb_alu_add_sub_int_float_convert;

   // Opcodes outside the enum; the unit must answer them with zero and error set.
   localparam logic [2:0] OP_RESERVED_6 = 3'd6;
   localparam logic [2:0] OP_RESERVED_7 = 3'd7;

   localparam int FRAC_W         = 23;
   localparam int RANDOM_COUNT   = 700;
   localparam int WATCHDOG_LIMIT = 1000;

   logic        clock;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [63:0] req_tdata  = '0;   // [31:0] operand_a, [63:32] operand_b
   logic [2:0]  req_tuser  = '0;   // [2:0] opcode
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [47:0] rsp_tdata;         // [31:0] result_value, [43:32] flag_word
   logic [0:0]  rsp_tuser;         // [0] error

   alu_asc_pkg::res_type pending_results[$];    // predicted responses, oldest first
   int      fail_count        = 0;
   int      responses_checked = 0;
   int      addsub_requests   = 0;
   int      convert_requests  = 0;
   int      reserved_requests = 0;
   int      burst_left        = 0;
   int      idle_cycles       = 0;

   alu_add_sub_int_float_convert dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // ---------------------------------------------------------------------------
   // Prediction
   // ---------------------------------------------------------------------------

   // Subtract adds the two's complement of b, so b == 0 gives carry 0.
   function automatic alu_asc_pkg::res_type add_sub_result(logic [31:0] a, logic [31:0] b,
                                                           logic negate_b,
                                                           logic error_on_carry);
      logic [31:0]          addend;
      logic [32:0]          wide;
      logic                 ovf;
      alu_asc_pkg::res_type r;
      addend = negate_b ? (~b + 32'd1) : b;
      wide   = {1'b0, a} + {1'b0, addend};
      // overflow: addends agree in sign, sum does not
      ovf    = (a[31] == addend[31]) && (wide[31] != a[31]);
      r                                  = '0;
      r.value                            = wide[31:0];
      r.flags[alu_asc_pkg::FLAG_OVF_BIT] = ovf;
      r.flags[alu_asc_pkg::FLAG_SGN_BIT] = wide[31];
      r.flags[alu_asc_pkg::FLAG_ZER_BIT] = (wide[31:0] == 32'd0);
      r.flags[alu_asc_pkg::FLAG_CRY_BIT] = wide[32];
      r.error                            = error_on_carry ? wide[32] : ovf;
      return r;
   endfunction

   // Signed integer to single precision, round to nearest even.
   function automatic logic [31:0] int_to_single(logic [31:0] a);
      logic [31:0] mag;
      logic [31:0] rem;
      logic [31:0] half;
      logic [31:0] mant;
      logic [7:0]  expo;
      int          lead;
      int          sh;
      mag = a[31] ? (~a + 32'd1) : a;
      if (mag == 32'd0) return 32'd0;
      lead = 0;
      for (int i = 0; i < 32; i++) if (mag[i]) lead = i;
      expo = 8'(lead + int'(alu_asc_pkg::EXP_BIAS));
      if (lead <= FRAC_W) begin
         mant = mag << (FRAC_W - lead);
      end else begin
         sh   = lead - FRAC_W;
         rem  = mag & ((32'd1 << sh) - 32'd1);
         half = 32'd1 << (sh - 1);
         mant = mag >> sh;
         if (rem > half || (rem == half && mant[0])) mant = mant + 32'd1;
         // rounding spilled past the hidden bit: renormalize
         if (mant[FRAC_W + 1]) begin
            mant = mant >> 1;
            expo = expo + 8'd1;
         end
      end
      return {a[31], expo, mant[FRAC_W-1:0]};
   endfunction

   // Single precision to integer, truncating; saturate above exponent 31.
   function automatic alu_asc_pkg::res_type single_to_int(logic [31:0] a);
      int                   unbiased;
      logic [31:0]          frac;
      logic [31:0]          mag;
      alu_asc_pkg::res_type r;
      r        = '0;
      unbiased = int'(a[30:23]) - int'(alu_asc_pkg::EXP_BIAS);
      if (unbiased > 31) begin
         r.value                            = a[31] ? alu_asc_pkg::SAT_NEG
                                                    : alu_asc_pkg::SAT_POS;
         r.flags[alu_asc_pkg::FLAG_OVF_BIT] = 1'b1;
         r.error                            = 1'b1;
         return r;
      end
      frac = {9'd0, a[FRAC_W-1:0]};
      mag  = 32'd0;
      if (unbiased >= 0 && unbiased <= FRAC_W)
         mag = (32'd1 << unbiased) | (frac >> (FRAC_W - unbiased));
      else if (unbiased > FRAC_W)
         mag = (32'd1 << unbiased) | (frac << (unbiased - FRAC_W));
      if (a[31]) mag = ~mag + 32'd1;
      r.value = mag;
      return r;
   endfunction

   function automatic alu_asc_pkg::res_type compute_alu_result(logic [2:0] code,
                                                               logic [31:0] a,
                                                               logic [31:0] b);
      alu_asc_pkg::res_type r;
      r = '0;
      case (code)
         alu_asc_pkg::OP_ADD:  r = add_sub_result(a, b, 1'b0, 1'b1);
         alu_asc_pkg::OP_ADDS: r = add_sub_result(a, b, 1'b0, 1'b0);
         alu_asc_pkg::OP_SUB:  r = add_sub_result(a, b, 1'b1, 1'b0);
         alu_asc_pkg::OP_SUBS: r = add_sub_result(a, b, 1'b1, 1'b0);
         alu_asc_pkg::OP_ITOF: r.value = int_to_single(a);
         alu_asc_pkg::OP_FTOI: r = single_to_int(a);
         default: r.error = 1'b1;
      endcase
      return r;
   endfunction

   // ---------------------------------------------------------------------------
   // Monitor: predict on each accepted request, check each accepted response
   // ---------------------------------------------------------------------------
   always @(posedge clock) begin
      alu_asc_pkg::res_type expected;
      if (!reset && req_tvalid && req_tready) begin
         pending_results.push_back(
            compute_alu_result(req_tuser, req_tdata[31:0], req_tdata[63:32]));
         if (req_tuser == alu_asc_pkg::OP_ITOF || req_tuser == alu_asc_pkg::OP_FTOI)
            convert_requests++;
         else if (req_tuser == OP_RESERVED_6 || req_tuser == OP_RESERVED_7)
            reserved_requests++;
         else addsub_requests++;
      end
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_results.size() == 0) begin
            $error("response with no request pending: tdata %h tuser %h",
                   rsp_tdata, rsp_tuser);
            fail_count++;
         end else begin
            expected = pending_results.pop_front();
            responses_checked++;
            if (rsp_tdata[31:0] !== expected.value) begin
               $error("result_value: expected %h, actual %h", expected.value,
                      rsp_tdata[31:0]);
               fail_count++;
            end
            if (rsp_tdata[43:32] !== expected.flags) begin
               $error("flag_word: expected %h, actual %h", expected.flags,
                      rsp_tdata[43:32]);
               fail_count++;
            end
            if (rsp_tuser[0] !== expected.error) begin
               $error("error: expected %b, actual %b", expected.error, rsp_tuser[0]);
               fail_count++;
            end
         end
      end
   end

   // Receiver: rotate a 16-bit ready pattern, re-chosen when its random age runs out.
   // Keep at least one ready bit per pattern; one draw in three never stalls.
   logic [15:0] ready_pattern = 16'hFFFF;
   int          pattern_age   = 0;

   always @(posedge clock) begin
      if (pattern_age == 0) begin
         ready_pattern = ($urandom_range(0, 2) == 0) ? 16'hFFFF : (16'($urandom) | 16'h0001);
         pattern_age   = $urandom_range(16, 96);
      end
      pattern_age--;
      rsp_tready   <= ready_pattern[0];
      ready_pattern = {ready_pattern[0], ready_pattern[15:1]};
   end

   // Watchdog: end the run when neither side moves anything for too long.
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
         end
      end
   end

   // ---------------------------------------------------------------------------
   // Stimulus
   // ---------------------------------------------------------------------------

   // Send one request; bursts of random length separated by random gaps.
   // Leave valid high on return so back-to-back requests follow without valid dropping.
   task automatic send_request(input logic [2:0] code, input logic [31:0] a,
                               input logic [31:0] b);
      int gap;
      if (burst_left == 0) begin
         gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
         burst_left = $urandom_range(1, 24);
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_tvalid <= 1'b1;
      req_tdata  <= {b, a};
      req_tuser  <= code;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   // Corner values, shifted values (random leading-one position) or full random.
   function automatic logic [31:0] random_operand();
      logic [31:0] v;
      case ($urandom_range(0, 3))
         0: begin
            case ($urandom_range(0, 5))
               0:       v = 32'h0000_0000;
               1:       v = 32'h0000_0001;
               2:       v = 32'h7FFF_FFFF;
               3:       v = 32'h8000_0000;
               4:       v = 32'hFFFF_FFFF;
               default: v = 32'h8000_0001;
            endcase
         end
         1: begin
            v = $urandom >> $urandom_range(0, 31);
            if ($urandom_range(0, 1)) v = ~v + 32'd1;
         end
         default: v = $urandom;
      endcase
      return v;
   endfunction

   // Carry, overflow in both directions, zero results, subtract of zero.
   task automatic test_add_sub_corners();
      send_request(alu_asc_pkg::OP_ADD,  32'hFFFF_FFFF, 32'h0000_0001);   // carry, zero
      send_request(alu_asc_pkg::OP_ADDS, 32'h7FFF_FFFF, 32'h0000_0001);   // positive overflow
      send_request(alu_asc_pkg::OP_ADDS, 32'h8000_0000, 32'h8000_0000);   // negative overflow
      send_request(alu_asc_pkg::OP_SUB,  32'h1234_5678, 32'h0000_0000);   // subtract zero
      send_request(alu_asc_pkg::OP_SUBS, 32'h8000_0000, 32'h0000_0001);   // subtract overflow
      send_request(alu_asc_pkg::OP_SUB,  32'hFFFF_FFFF, 32'hFFFF_FFFF);   // equal operands
   endtask

   // Zero, most negative value, exact fit, tie to even, rounding into the exponent.
   task automatic test_int_to_float_corners();
      send_request(alu_asc_pkg::OP_ITOF, 32'h0000_0000, 32'hFFFF_FFFF);
      send_request(alu_asc_pkg::OP_ITOF, 32'h8000_0000, 32'h0000_0000);
      send_request(alu_asc_pkg::OP_ITOF, 32'h00FF_FFFF, 32'h0000_0000);
      send_request(alu_asc_pkg::OP_ITOF, 32'h0100_0001, 32'h0000_0000);   // tie, stays even
      send_request(alu_asc_pkg::OP_ITOF, 32'h0100_0003, 32'h0000_0000);   // tie, rounds up
      send_request(alu_asc_pkg::OP_ITOF, 32'h01FF_FFFF, 32'h0000_0000);   // round carries
      send_request(alu_asc_pkg::OP_ITOF, 32'h7FFF_FFFF, 32'h0000_0000);
      send_request(alu_asc_pkg::OP_ITOF, 32'hFFFF_FFFF, 32'h0000_0000);
   endtask

   // Zero and denormal, fractions, exponent 31 and 32, negative infinity and NaN.
   task automatic test_float_to_int_corners();
      send_request(alu_asc_pkg::OP_FTOI, 32'h0000_0000, 32'h0000_0000);
      send_request(alu_asc_pkg::OP_FTOI, 32'h8000_0001, 32'h0000_0000);   // negative denormal
      send_request(alu_asc_pkg::OP_FTOI, 32'h3F00_0000, 32'h0000_0000);   // 0.5 truncates
      send_request(alu_asc_pkg::OP_FTOI, 32'hBFC0_0000, 32'h0000_0000);   // -1.5
      send_request(alu_asc_pkg::OP_FTOI, 32'h4F7F_FFFF, 32'h0000_0000);   // exponent 31
      send_request(alu_asc_pkg::OP_FTOI, 32'hCF00_0000, 32'h0000_0000);   // exponent 31, neg
      send_request(alu_asc_pkg::OP_FTOI, 32'h4F80_0000, 32'h0000_0000);   // exponent 32
      send_request(alu_asc_pkg::OP_FTOI, 32'hFF80_0000, 32'h0000_0000);   // negative infinity
      send_request(alu_asc_pkg::OP_FTOI, 32'h7FC0_0000, 32'h0000_0000);   // NaN
   endtask

   task automatic test_reserved_opcodes();
      send_request(OP_RESERVED_6, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_request(OP_RESERVED_7, 32'h0000_0001, 32'h8000_0000);
   endtask

   // Mixed random requests; shape operands so each path sees its interesting range.
   task automatic test_random_mix(input int count);
      logic [2:0]  code;
      logic [31:0] a;
      logic [31:0] b;
      logic [7:0]  expo_field;
      int          pick;
      for (int n = 0; n < count; n++) begin
         pick = $urandom_range(0, 99);
         if (pick < 4) code = pick[0] ? OP_RESERVED_7 : OP_RESERVED_6;
         else code = 3'($urandom_range(0, 5));
         a = random_operand();
         b = random_operand();
         if (code == alu_asc_pkg::OP_FTOI) begin
            // keep most exponents near the integer range, the rest anywhere
            expo_field = ($urandom_range(0, 9) < 7) ? 8'($urandom_range(100, 165))
                                                    : 8'($urandom);
            a = {a[31], expo_field, a[22:0]};
         end else if ($urandom_range(0, 7) == 0) begin
            // force zero results on add and subtract
            b = (code == alu_asc_pkg::OP_SUB || code == alu_asc_pkg::OP_SUBS) ? a
                                                                               : (~a + 32'd1);
         end
         send_request(code, a, b);
      end
   endtask

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      test_add_sub_corners();
      test_int_to_float_corners();
      test_float_to_int_corners();
      test_reserved_opcodes();
      test_random_mix(RANDOM_COUNT);

      req_tvalid <= 1'b0;
      // drain: wait for every predicted response before reporting
      while (pending_results.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);

      $display("Run covered %0d add/subtract, %0d conversion and %0d reserved-opcode requests;",
               addsub_requests, convert_requests, reserved_requests);
      $display("%0d responses compared, %0d mismatches.", responses_checked, fail_count);
      if (fail_count == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
